### design/heightmap_bilinear_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Height map sampler assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define HBS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define HBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/hbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Height map sampler package
// Shared widths, request codes, register indexes and store control type.
// ----------------------------------------------------------------------------
package hbs_pkg;

   localparam int DEF_MAX_WIDTH = 256;
   localparam int DEF_MAX_DEPTH = 256;
   localparam int DEF_FRAC_BITS = 8;

   localparam int CFG_W       = 9;
   localparam int POS_W       = 17;
   localparam int VAL_W       = 16;
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_DEPTH = 1'd1;

   // Request kinds carried in tuser
   localparam logic [REQ_TUSER_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [REQ_TUSER_W-1:0] REQ_POINT  = 2'd1;
   localparam logic [REQ_TUSER_W-1:0] REQ_INTERP = 2'd2;

   // Control word from the sequencer to the height store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } hbs_ram_ctl_type;

endpackage
`default_nettype wire

### design/heightmap_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Height map bilinear sampler
// Stores Q0.16 heights, answers point reads and bilinear interpolated reads.
// ----------------------------------------------------------------------------
// A point read passes CALC, RD0, RD1 and FIN before its result is valid, an
// interpolated read CALC, RD0, RD1, BL1, BL2 and FIN; a write passes CALC and
// gives no result. One word is in flight at a time: a new word is taken once the
// previous result sits in the output register, and FIN holds while that register
// is full and not taken. The two-port store reads the four corners in RD0 and
// RD1, and the three blend steps run one after another.
// Reset (synchronous) clears control state and sets both sizes to 256; the
// height store is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit #(
   parameter int MAX_WIDTH = hbs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_DEPTH = hbs_pkg::DEF_MAX_DEPTH,
   parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hbs_pkg::REQ_TDATA_W-1:0]    req_tdata,  // pos_x, pos_z, write_value
   input  logic [hbs_pkg::REQ_TUSER_W-1:0]    req_tuser,  // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // height
   // configuration port
   input  logic                               csr_we,
   input  logic [hbs_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [hbs_pkg::CFG_W-1:0]          csr_wdata
);
   import hbs_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   // Clamped coordinate must hold both a raw position and (size-1) << FRAC_BITS
   localparam int CPW   = (CFG_W + FRAC_BITS > POS_W) ? CFG_W + FRAC_BITS : POS_W;
   localparam int BW    = VAL_W + FRAC_BITS + 2;
   localparam logic signed [BW-1:0] HALF = BW'(2 ** (FRAC_BITS - 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_RD0,
      S_RD1,
      S_BL1,
      S_BL2,
      S_FIN
   } state_type;

   // Blend a toward b by weight t, rounded to nearest:
   // (a * (1 - t) + b * t + half) >> FRAC_BITS, written as a + (b - a) * t.
   function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] t);
      logic signed [VAL_W:0]  diff;
      logic signed [BW-1:0]   acc;
      diff = signed'({1'b0, b}) - signed'({1'b0, a});
      acc  = (BW'(signed'({1'b0, a})) <<< FRAC_BITS)
           + BW'(diff) * BW'(signed'({1'b0, t}))
           + HALF;
      return acc[FRAC_BITS +: VAL_W];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [CFG_W-1:0] z,
                                               input logic [CFG_W-1:0] x);
      return AW'(z) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   // Registers
   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        map_width_ff, map_width_in;
   logic [CFG_W-1:0]        map_depth_ff, map_depth_in;
   logic [REQ_TUSER_W-1:0]  kind_ff, kind_in;
   logic [POS_W-1:0]        px_ff, px_in;
   logic [POS_W-1:0]        pz_ff, pz_in;
   logic [VAL_W-1:0]        wv_ff, wv_in;
   logic [AW-1:0]           a00_ff, a00_in;
   logic [AW-1:0]           a10_ff, a10_in;
   logic [AW-1:0]           a01_ff, a01_in;
   logic [AW-1:0]           a11_ff, a11_in;
   logic [FRAC_BITS-1:0]    tx_ff, tx_in;
   logic [FRAC_BITS-1:0]    tz_ff, tz_in;
   logic                    inside_ff, inside_in;
   logic                    empty_ff, empty_in;
   logic [VAL_W-1:0]        h0_ff, h0_in;
   logic [VAL_W-1:0]        h1_ff, h1_in;
   logic [VAL_W-1:0]        res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]        rsp_data_ff, rsp_data_in;

   // Geometry decode of the held word
   logic [CFG_W-1:0]        eff_w, eff_d;
   logic [CFG_W-1:0]        cell_x, cell_z;
   logic                    inside_c;
   logic [CPW-1:0]          hi_x, hi_z, pos_x_c, pos_z_c, fx, fz;
   logic [CFG_W-1:0]        x0, z0, x1, z1;
   logic [AW-1:0]           pt_addr;

   // Store interface
   hbs_ram_ctl_type         ram_ctl;
   logic [AW-1:0]           rd_addr_a, rd_addr_b;
   logic [VAL_W-1:0]        rd_data_a, rd_data_b;
   logic                    req_fire;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sizes above the maximum act as the maximum
   assign eff_w = (int'(map_width_ff) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : map_width_ff;
   assign eff_d = (int'(map_depth_ff) > MAX_DEPTH) ? CFG_W'(MAX_DEPTH) : map_depth_ff;

   // Integer cell for write and point read; negative positions are outside
   assign cell_x   = CFG_W'(px_ff[POS_W-1:FRAC_BITS]);
   assign cell_z   = CFG_W'(pz_ff[POS_W-1:FRAC_BITS]);
   assign inside_c = !px_ff[POS_W-1] && !pz_ff[POS_W-1]
                   && (POS_W'(px_ff[POS_W-1:FRAC_BITS]) < POS_W'(eff_w))
                   && (POS_W'(pz_ff[POS_W-1:FRAC_BITS]) < POS_W'(eff_d));
   assign pt_addr  = cell_addr(cell_z, cell_x);

   // Clamp to [0, (size-1) << FRAC_BITS]; an empty map is overridden later
   assign hi_x    = CPW'(eff_w - CFG_W'(1)) << FRAC_BITS;
   assign hi_z    = CPW'(eff_d - CFG_W'(1)) << FRAC_BITS;
   assign pos_x_c = CPW'(px_ff[POS_W-2:0]);
   assign pos_z_c = CPW'(pz_ff[POS_W-2:0]);
   assign fx = px_ff[POS_W-1] ? '0 : ((pos_x_c > hi_x) ? hi_x : pos_x_c);
   assign fz = pz_ff[POS_W-1] ? '0 : ((pos_z_c > hi_z) ? hi_z : pos_z_c);
   assign x0 = fx[FRAC_BITS +: CFG_W];
   assign z0 = fz[FRAC_BITS +: CFG_W];
   // Neighbor cell, held at the last column or row
   assign x1 = (x0 == eff_w - CFG_W'(1)) ? x0 : x0 + CFG_W'(1);
   assign z1 = (z0 == eff_d - CFG_W'(1)) ? z0 : z0 + CFG_W'(1);

   // Store ports: top row in the first read cycle, bottom row in the second
   assign ram_ctl.wr_en = (state_ff == S_CALC) && (kind_ff == REQ_WRITE) && inside_c;
   assign ram_ctl.rd_en = (state_ff == S_RD0) || (state_ff == S_RD1);
   assign rd_addr_a     = (state_ff == S_RD0) ? a00_ff : a01_ff;
   assign rd_addr_b     = (state_ff == S_RD0) ? a10_ff : a11_ff;

   hbs_height_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_hbs_height_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .wr_addr   (pt_addr),
      .wr_data   (wv_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Configuration writes
   always_comb begin
      map_width_in = map_width_ff;
      map_depth_in = map_depth_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MAP_WIDTH: map_width_in = csr_wdata;
            CSR_MAP_DEPTH: map_depth_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      px_in        = px_ff;
      pz_in        = pz_ff;
      wv_in        = wv_ff;
      a00_in       = a00_ff;
      a10_in       = a10_ff;
      a01_in       = a01_ff;
      a11_in       = a11_ff;
      tx_in        = tx_ff;
      tz_in        = tz_ff;
      inside_in    = inside_ff;
      empty_in     = empty_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the output word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               px_in    = req_tdata[POS_W-1:0];
               pz_in    = req_tdata[2*POS_W-1:POS_W];
               wv_in    = req_tdata[2*POS_W +: VAL_W];
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            // write happens on the store port this cycle
            inside_in = inside_c;
            empty_in  = (eff_w == '0) || (eff_d == '0);
            tx_in     = fx[FRAC_BITS-1:0];
            tz_in     = fz[FRAC_BITS-1:0];
            if (kind_ff == REQ_INTERP) begin
               a00_in = cell_addr(z0, x0);
               a10_in = cell_addr(z0, x1);
               a01_in = cell_addr(z1, x0);
               a11_in = cell_addr(z1, x1);
            end else begin
               a00_in = pt_addr;
               a10_in = pt_addr;
               a01_in = pt_addr;
               a11_in = pt_addr;
            end
            case (kind_ff) inside
               REQ_POINT, REQ_INTERP: state_in = S_RD0;
               default:               state_in = S_IDLE;
            endcase
         end
         S_RD0: begin
            state_in = S_RD1;
         end
         S_RD1: begin
            // top row data is back
            if (kind_ff == REQ_POINT) begin
               res_in   = inside_ff ? rd_data_a : '0;
               state_in = S_FIN;
            end else begin
               h0_in    = blend(rd_data_a, rd_data_b, tx_ff);
               state_in = S_BL1;
            end
         end
         S_BL1: begin
            h1_in    = blend(rd_data_a, rd_data_b, tx_ff);
            state_in = S_BL2;
         end
         S_BL2: begin
            res_in   = empty_ff ? '0 : blend(h0_ff, h1_ff, tz_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         map_width_ff <= CFG_SIZE_RESET;
         map_depth_ff <= CFG_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         map_width_ff <= map_width_in;
         map_depth_ff <= map_depth_in;
      end
      kind_ff     <= kind_in;
      px_ff       <= px_in;
      pz_ff       <= pz_in;
      wv_ff       <= wv_in;
      a00_ff      <= a00_in;
      a10_ff      <= a10_in;
      a01_ff      <= a01_in;
      a11_ff      <= a11_in;
      tx_ff       <= tx_in;
      tz_ff       <= tz_in;
      inside_ff   <= inside_in;
      empty_ff    <= empty_in;
      h0_ff       <= h0_in;
      h1_ff       <= h1_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

### design/hbs_height_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Height store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hbs_height_ram #(
   parameter int DEPTH = hbs_pkg::DEF_MAX_WIDTH * hbs_pkg::DEF_MAX_DEPTH,
   parameter int AW    = $clog2(hbs_pkg::DEF_MAX_WIDTH * hbs_pkg::DEF_MAX_DEPTH)
) (
   input  logic                         clock,
   input  hbs_pkg::hbs_ram_ctl_type     ctl,
   input  logic [AW-1:0]                wr_addr,
   input  logic [hbs_pkg::VAL_W-1:0]    wr_data,
   input  logic [AW-1:0]                rd_addr_a,
   input  logic [AW-1:0]                rd_addr_b,
   output logic [hbs_pkg::VAL_W-1:0]    rd_data_a,
   output logic [hbs_pkg::VAL_W-1:0]    rd_data_b
);
   import hbs_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

### design/hbs_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Height map sampler port checker
// Watches the top-level ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "heightmap_bilinear_sampler_unit_macros.svh"

module hbs_port_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [hbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   // a stalled result word holds
   `HBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // one word in flight: busy right after an accept
   `HBS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "input taken again right after an accept")

   // no result can appear the cycle after an accept
   `HBS_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_fire, !$rose(rsp_tvalid), "result appeared one cycle after accept")

   // a new result only comes while the block is busy
   `HBS_ASSERT_IMPLIES(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result rose while block was idle")

endmodule

bind heightmap_bilinear_sampler_unit hbs_port_checker u_hbs_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
